>>> rtl/infix_to_postfix_converter_unit_defines.svh
// assertion macros for the infix to postfix converter
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define I2P_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2p assertion failed");

// antecedent implies consequent in the next cycle
`define I2P_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2p assertion failed");

`endif

>>> rtl/i2p_pkg.sv
// shared types, codes and lookup functions for the infix to postfix converter
package i2p_pkg;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_MUL     = 3'd2,
        OP_DIV     = 3'd3,
        OP_POW     = 3'd4,
        OP_LPAREN  = 3'd5,
        OP_RPAREN  = 3'd6,
        OP_OPERAND = 3'd7
    } op_code_t;

    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_CARET  = 8'h5E;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;

    localparam int unsigned MAX_RESULTS = 34;
    localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [7:0] char_in;
        logic       expr_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       has_char;
        logic       out_last;
        logic       overflow;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic pop;
        logic push;
        logic finish;
    } i2p_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_operand;
        logic in_rparen;
        logic in_last;
        logic last;
        logic empty;
        logic top_lparen;
        logic breaks;
        logic can_pop;
        logic finish_ok;
        logic overflow;
    } i2p_sts_t;

    function automatic op_code_t classify(input logic [7:0] c);
        op_code_t k;
        case (c)
            CHAR_PLUS:   k = OP_ADD;
            CHAR_MINUS:  k = OP_SUB;
            CHAR_STAR:   k = OP_MUL;
            CHAR_SLASH:  k = OP_DIV;
            CHAR_CARET:  k = OP_POW;
            CHAR_LPAREN: k = OP_LPAREN;
            CHAR_RPAREN: k = OP_RPAREN;
            default:     k = OP_OPERAND;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] code_char(input op_code_t op);
        logic [7:0] c;
        case (op)
            OP_ADD:    c = CHAR_PLUS;
            OP_SUB:    c = CHAR_MINUS;
            OP_MUL:    c = CHAR_STAR;
            OP_DIV:    c = CHAR_SLASH;
            OP_POW:    c = CHAR_CARET;
            OP_LPAREN: c = CHAR_LPAREN;
            default:   c = 8'h00;
        endcase
        return c;
    endfunction

    // precedence of an arriving operator
    function automatic logic [2:0] prec_out(input op_code_t op);
        logic [2:0] p;
        case (op)
            OP_ADD, OP_SUB: p = 3'd1;
            OP_MUL, OP_DIV: p = 3'd3;
            OP_POW:         p = 3'd6;
            OP_LPAREN:      p = 3'd7;
            default:        p = 3'd0;
        endcase
        return p;
    endfunction

    // precedence of an operator sitting on the stack
    function automatic logic [2:0] prec_in(input op_code_t op);
        logic [2:0] p;
        case (op)
            OP_ADD, OP_SUB: p = 3'd2;
            OP_MUL, OP_DIV: p = 3'd4;
            OP_POW:         p = 3'd5;
            default:        p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

>>> rtl/i2p_ctrl.sv
// sequencing state machine for the infix to postfix converter
module i2p_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            infix_valid,
    output logic            infix_stall,
    input  i2p_pkg::i2p_sts_t sts,
    output i2p_pkg::i2p_cmd_t cmd
);
    import i2p_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPER,
        ST_CLOSE,
        ST_FLUSH,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t end_state;

    assign infix_stall = (state_reg != ST_IDLE);
    assign end_state   = sts.last ? ST_FLUSH : ST_FINISH;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (infix_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.in_operand)
                        state_next = sts.in_last ? ST_FLUSH : ST_FINISH;
                    else if (sts.in_rparen)
                        state_next = ST_CLOSE;
                    else
                        state_next = ST_OPER;
                end
            end
            ST_OPER:
            begin
                if (!sts.empty && !sts.breaks)
                begin
                    cmd.pop = sts.can_pop;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = end_state;
                end
            end
            ST_CLOSE:
            begin
                if (sts.empty)
                begin
                    state_next = end_state;
                end
                else if (sts.top_lparen)
                begin
                    // matching open paren is dropped silently
                    cmd.pop    = 1'b1;
                    state_next = end_state;
                end
                else
                begin
                    cmd.pop = sts.can_pop;
                end
            end
            ST_FLUSH:
            begin
                if (sts.empty)
                    state_next = ST_FINISH;
                else
                    cmd.pop = sts.can_pop;
            end
            ST_FINISH:
            begin
                if (sts.finish_ok)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/i2p_datapath.sv
// operator stack, held result and output register of the infix to postfix converter
module i2p_datapath #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  i2p_pkg::i2p_cmd_t    cmd,
    output i2p_pkg::i2p_sts_t    sts,
    input  i2p_pkg::in_item_t    infix_item,
    output logic                 postfix_valid,
    input  logic                 postfix_stall,
    output i2p_pkg::out_item_t   postfix_item
);
    import i2p_pkg::*;

    localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

    logic [2:0]           stack_mem [STACK_DEPTH];
    op_code_t             top_reg;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    op_code_t             kind_reg, kind_next;
    logic                 last_reg, last_next;
    logic [RES_CNT_W-1:0] n_reg, n_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [7:0]           pend_char_reg, pend_char_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_item_reg, out_item_next;

    op_code_t             in_kind;
    logic                 empty;
    logic                 full;
    logic                 out_free;
    logic                 emit_now;
    logic                 emit_if_pop;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;

    assign in_kind  = classify(infix_item.char_in);
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign out_free = !out_valid_reg || !postfix_stall;

    // a pop makes a character unless it is an open paren or the result cap is reached
    assign emit_if_pop = (top_reg != OP_LPAREN) && (n_reg < RES_CNT_W'(MAX_RESULTS));
    assign emit_now    = cmd.pop && emit_if_pop;

    // new top after a pop sits one below the current top
    assign rd_addr = (count_reg > CNT_W'(1)) ? IDX_W'(count_reg - CNT_W'(2)) : '0;
    assign wr_addr = IDX_W'(count_reg);

    assign sts.in_operand = (in_kind == OP_OPERAND);
    assign sts.in_rparen  = (in_kind == OP_RPAREN);
    assign sts.in_last    = infix_item.expr_end;
    assign sts.last       = last_reg;
    assign sts.empty      = empty;
    assign sts.top_lparen = (top_reg == OP_LPAREN);
    assign sts.breaks     = (prec_out(kind_reg) > prec_in(top_reg));
    assign sts.can_pop    = !(emit_if_pop && pend_valid_reg) || out_free;
    assign sts.finish_ok  = !(pend_valid_reg || last_reg) || out_free;
    assign sts.overflow   = ovf_reg;

    always_comb
    begin
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        kind_next       = kind_reg;
        last_next       = last_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;

        if (!postfix_stall)
            out_valid_next = 1'b0;

        if (cmd.load)
        begin
            kind_next       = in_kind;
            last_next       = infix_item.expr_end;
            pend_char_next  = infix_item.char_in;
            pend_valid_next = (in_kind == OP_OPERAND);
            n_next          = (in_kind == OP_OPERAND) ? RES_CNT_W'(1) : '0;
        end

        if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
            if (emit_now)
            begin
                // the held item goes out, the popped operator takes its place
                if (pend_valid_reg)
                begin
                    out_valid_next         = 1'b1;
                    out_item_next.char_out = pend_char_reg;
                    out_item_next.has_char = 1'b1;
                    out_item_next.out_last = 1'b0;
                    out_item_next.overflow = ovf_reg;
                end
                pend_valid_next = 1'b1;
                pend_char_next  = code_char(top_reg);
                n_next          = n_reg + RES_CNT_W'(1);
            end
        end

        if (cmd.push)
        begin
            if (full)
                ovf_next = 1'b1;
            else
                count_next = count_reg + CNT_W'(1);
        end

        if (cmd.finish)
        begin
            if (pend_valid_reg || last_reg)
            begin
                out_valid_next         = 1'b1;
                out_item_next.char_out = pend_valid_reg ? pend_char_reg : 8'h00;
                out_item_next.has_char = pend_valid_reg;
                out_item_next.out_last = last_reg;
                out_item_next.overflow = ovf_reg;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        last_reg      <= last_next;
        n_reg         <= n_next;
        pend_char_reg <= pend_char_next;
        out_item_reg  <= out_item_next;
    end

    // stack memory with a registered top of stack
    always_ff @(posedge clk)
    begin
        if (cmd.push && !full)
        begin
            stack_mem[wr_addr] <= kind_reg;
            top_reg            <= kind_reg;
        end
        else if (cmd.pop)
        begin
            top_reg <= op_code_t'(stack_mem[rd_addr]);
        end
    end

    assign postfix_valid = out_valid_reg;
    assign postfix_item  = out_item_reg;

endmodule

>>> rtl/infix_to_postfix_converter_unit.sv
// top level of the infix to postfix converter: controller, datapath and checks
// an operand item goes from accept to the finish step; an operator pops in the operator step
// until it may push, a ')' pops down to '(' or an empty stack; a last item flushes the stack
// a result is offered the cycle after its pop or finish step; a stalled output holds the pops
// pops of the operator stack go one entry at a time through the single stack read port
// rst_n clears the stack count, overflow flag, held item and output register at once
`include "infix_to_postfix_converter_unit_defines.svh"

module infix_to_postfix_converter_unit #(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               infix_valid,
    output logic               infix_stall,
    input  i2p_pkg::in_item_t  infix_item,
    output logic               postfix_valid,
    input  logic               postfix_stall,
    output i2p_pkg::out_item_t postfix_item
);
    import i2p_pkg::*;

    i2p_cmd_t cmd;
    i2p_sts_t sts;

    i2p_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .infix_valid (infix_valid),
        .infix_stall (infix_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    i2p_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .infix_item    (infix_item),
        .postfix_valid (postfix_valid),
        .postfix_stall (postfix_stall),
        .postfix_item  (postfix_item)
    );

    // one item in flight at a time
    `I2P_ASSERT_NEXT(a_busy_after_accept, infix_valid && !infix_stall, infix_stall)
    // dropped push is remembered until reset
    `I2P_ASSERT_NEXT(a_overflow_sticky, sts.overflow, sts.overflow)
    // controller never pops an empty stack
    `I2P_ASSERT_NOW(a_no_pop_when_empty, cmd.pop, !sts.empty)

endmodule

>>> verif/i2p_postfix_checker.sv
// channel monitor and shunting-yard predictor for the infix to postfix converter
`timescale 1ns / 100ps

module i2p_postfix_checker
    import i2p_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       infix_valid,
    input  logic       infix_stall,
    input  in_item_t   infix_item,
    input  logic       postfix_valid,
    input  logic       postfix_stall,
    input  out_item_t  postfix_item,
    output int         errors,
    output int         pending
);

    op_code_t  op_stk [STACK_DEPTH];
    int        op_depth;
    logic      ovf_sticky;
    out_item_t postfix_due [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic op_code_t decode_char(input logic [7:0] c);
        op_code_t k;
        k = OP_OPERAND;
        if (c == CHAR_PLUS)   k = OP_ADD;
        if (c == CHAR_MINUS)  k = OP_SUB;
        if (c == CHAR_STAR)   k = OP_MUL;
        if (c == CHAR_SLASH)  k = OP_DIV;
        if (c == CHAR_CARET)  k = OP_POW;
        if (c == CHAR_LPAREN) k = OP_LPAREN;
        if (c == CHAR_RPAREN) k = OP_RPAREN;
        return k;
    endfunction

    function automatic logic [7:0] op_glyph(input op_code_t op);
        logic [7:0] g;
        case (op)
            OP_ADD:  g = CHAR_PLUS;
            OP_SUB:  g = CHAR_MINUS;
            OP_MUL:  g = CHAR_STAR;
            OP_DIV:  g = CHAR_SLASH;
            OP_POW:  g = CHAR_CARET;
            default: g = CHAR_LPAREN;
        endcase
        return g;
    endfunction

    // binding strength of an operator as it arrives
    function automatic int rank_arriving(input op_code_t op);
        int r;
        case (op)
            OP_ADD, OP_SUB: r = 1;
            OP_MUL, OP_DIV: r = 3;
            OP_POW:         r = 6;
            default:        r = 7;
        endcase
        return r;
    endfunction

    // binding strength once stacked; ^ drops below its arriving rank
    function automatic int rank_stacked(input op_code_t op);
        int r;
        case (op)
            OP_ADD, OP_SUB: r = 2;
            OP_MUL, OP_DIV: r = 4;
            OP_POW:         r = 5;
            default:        r = 0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("postfix mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic shunt_char(input in_item_t it);
        op_code_t   kind;
        op_code_t   top;
        logic [7:0] emitted [$];
        out_item_t  r;
        int         i;
        kind = decode_char(it.char_in);
        if (kind == OP_OPERAND)
        begin
            emitted.push_back(it.char_in);
        end
        else if (kind == OP_RPAREN)
        begin
            while (op_depth > 0)
            begin
                op_depth--;
                top = op_stk[op_depth];
                if (top == OP_LPAREN)
                    break;
                emitted.push_back(op_glyph(top));
            end
        end
        else
        begin
            while (op_depth > 0)
            begin
                top = op_stk[op_depth - 1];
                if (rank_arriving(kind) > rank_stacked(top))
                    break;
                op_depth--;
                if (top != OP_LPAREN)
                    emitted.push_back(op_glyph(top));
            end
            if (op_depth < STACK_DEPTH)
            begin
                op_stk[op_depth] = kind;
                op_depth++;
            end
            else
            begin
                ovf_sticky = 1'b1;
            end
        end
        if (it.expr_end)
        begin
            while (op_depth > 0)
            begin
                op_depth--;
                if (op_stk[op_depth] != OP_LPAREN)
                    emitted.push_back(op_glyph(op_stk[op_depth]));
            end
        end
        if (emitted.size() > MAX_RESULTS)
            emitted = emitted[0:MAX_RESULTS - 1];
        for (i = 0; i < emitted.size(); i++)
        begin
            r.char_out = emitted[i];
            r.has_char = 1'b1;
            r.out_last = it.expr_end && (i == emitted.size() - 1);
            r.overflow = ovf_sticky;
            postfix_due.push_back(r);
        end
        // an end item with nothing to emit still closes the expression
        if (it.expr_end && emitted.size() == 0)
        begin
            r.char_out = 8'h00;
            r.has_char = 1'b0;
            r.out_last = 1'b1;
            r.overflow = ovf_sticky;
            postfix_due.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            op_depth   = 0;
            ovf_sticky = 1'b0;
            postfix_due.delete();
            pending    = 0;
        end
        else
        begin
            if (infix_valid && !infix_stall)
                shunt_char(infix_item);
            if (postfix_valid && !postfix_stall)
            begin
                if (postfix_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected item %h", postfix_item));
                end
                else
                begin
                    want = postfix_due.pop_front();
                    if (postfix_item.char_out !== want.char_out)
                        report_mismatch($sformatf("char_out %h, want %h",
                            postfix_item.char_out, want.char_out));
                    if (postfix_item.has_char !== want.has_char)
                        report_mismatch($sformatf("has_char %b, want %b",
                            postfix_item.has_char, want.has_char));
                    if (postfix_item.out_last !== want.out_last)
                        report_mismatch($sformatf("out_last %b, want %b",
                            postfix_item.out_last, want.out_last));
                    if (postfix_item.overflow !== want.overflow)
                        report_mismatch($sformatf("overflow %b, want %b",
                            postfix_item.overflow, want.overflow));
                end
            end
            pending = postfix_due.size();
        end
    end

endmodule

>>> verif/tb_infix_to_postfix_converter_unit.sv
// stimulus, flow control and verdict for the infix to postfix converter
`timescale 1ns / 100ps

module tb_infix_to_postfix_converter_unit;
    import i2p_pkg::*;

    localparam int unsigned STACK_DEPTH = 32;
    localparam int          RANDOM_ITEMS = 100;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          SETTLE_CYCLES = 100;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

    logic      clk;
    logic      rst_n;
    logic      infix_valid;
    logic      infix_stall;
    in_item_t  infix_item;
    logic      postfix_valid;
    logic      postfix_stall;
    out_item_t postfix_item;

    int        errors;
    int        pending;
    int        items_sent;
    int        burst_left;
    int        cycle_count;
    bit        hold_go;

    logic [7:0] op_glyphs [5] = '{CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH, CHAR_CARET};
    logic [7:0] expr_q [$];

    infix_to_postfix_converter_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .infix_valid(infix_valid),
        .infix_stall(infix_stall),
        .infix_item(infix_item),
        .postfix_valid(postfix_valid),
        .postfix_stall(postfix_stall),
        .postfix_item(postfix_item)
    );

    i2p_postfix_checker #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .infix_valid(infix_valid),
        .infix_stall(infix_stall),
        .infix_item(infix_item),
        .postfix_valid(postfix_valid),
        .postfix_stall(postfix_stall),
        .postfix_item(postfix_item),
        .errors(errors),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_infix_to_postfix_converter_unit: errors");
            $finish;
        end
    end

    // receiver: shifting stall patterns plus one long hold-off
    initial
    begin
        rx_mode_t mode;
        int       span;
        int       hold_left;
        bit       held;
        mode          = RX_FREE;
        span          = 0;
        hold_left     = 0;
        held          = 1'b0;
        postfix_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !held)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                postfix_stall <= 1'b1;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(16, 80);
                end
                span--;
                case (mode)
                    RX_FREE:  postfix_stall <= 1'b0;
                    RX_LIGHT: postfix_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: postfix_stall <= ($urandom_range(0, 3) != 0);
                    default:  postfix_stall <= ~postfix_stall;
                endcase
            end
        end
    end

    // one item per call, sender bursts and gaps handled here
    task automatic put_char(input logic [7:0] c, input logic last);
        if (burst_left == 0)
        begin
            infix_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        infix_valid <= 1'b1;
        infix_item  <= {c, last};
        do @(posedge clk); while (infix_stall);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            put_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_queue();
        int i;
        for (i = 0; i < expr_q.size(); i++)
            put_char(expr_q[i], i == expr_q.size() - 1);
    endtask

    // sender waits for every outstanding result
    task automatic drain();
        infix_valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending != 0);
    endtask

    function automatic logic [7:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return 8'h61 + 8'($urandom_range(0, 25));
        if (sel < 8)
            return 8'h30 + 8'($urandom_range(0, 9));
        return 8'($urandom_range(128, 255));
    endfunction

    function automatic logic [7:0] pick_noise();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return op_glyphs[$urandom_range(0, 4)];
        if (sel == 4)
            return CHAR_LPAREN;
        if (sel == 5)
            return CHAR_RPAREN;
        return 8'($urandom_range(0, 255));
    endfunction

    // well-formed expression with random nesting into expr_q
    task automatic build_expr(input int max_terms, input int max_open);
        int terms;
        int depth;
        int t;
        int n;
        expr_q.delete();
        terms = $urandom_range(1, max_terms);
        depth = 0;
        for (t = 0; t < terms; t++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(1, max_open);
                repeat (n) expr_q.push_back(CHAR_LPAREN);
                depth += n;
            end
            expr_q.push_back(pick_operand());
            if (depth > 0 && $urandom_range(0, 1) == 0)
            begin
                n = $urandom_range(1, depth);
                repeat (n) expr_q.push_back(CHAR_RPAREN);
                depth -= n;
            end
            if (t < terms - 1)
                expr_q.push_back(op_glyphs[$urandom_range(0, 4)]);
        end
        repeat (depth) expr_q.push_back(CHAR_RPAREN);
    endtask

    task automatic send_random_expr();
        int kind;
        int n;
        int i;
        kind = $urandom_range(0, 19);
        if (kind < 14)
        begin
            if ($urandom_range(0, 5) == 0)
                build_expr(10, 6);
            else
                build_expr(6, 2);
            send_queue();
        end
        else if (kind < 17)
        begin
            // broken expression: one character dropped or swapped for a paren
            build_expr(6, 2);
            i = $urandom_range(0, expr_q.size() - 1);
            if ($urandom_range(0, 1) == 0 && expr_q.size() > 1)
                expr_q.delete(i);
            else
                expr_q[i] = ($urandom_range(0, 1) == 0) ? CHAR_RPAREN : CHAR_LPAREN;
            send_queue();
        end
        else
        begin
            n = $urandom_range(1, 10);
            for (i = 0; i < n; i++)
                put_char(pick_noise(), (i == n - 1) || ($urandom_range(0, 7) == 0));
        end
    endtask

    initial
    begin
        int  random_start;
        bit  mid_drained;
        rst_n       = 1'b0;
        infix_valid = 1'b0;
        infix_item  = '0;
        items_sent  = 0;
        burst_left  = 0;
        hold_go     = 1'b0;
        mid_drained = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // precedence, associativity and parens in one expression
        send_text("(a+b)*c-d/e^f^g");
        // unmatched close on an empty stack, end with nothing to emit
        send_text(")");
        // lone open paren removed silently at the end
        send_text("(");
        send_text("a+(b");
        // byte extremes as operands
        put_char(8'h00, 1'b0);
        put_char(CHAR_MINUS, 1'b0);
        put_char(8'hFF, 1'b1);
        drain();

        random_start = items_sent;
        while (items_sent < random_start + RANDOM_ITEMS)
        begin
            send_random_expr();
            if (!hold_go && items_sent > random_start + 30)
                hold_go = 1'b1;
            if (!mid_drained && items_sent > random_start + 70)
            begin
                mid_drained = 1'b1;
                drain();
            end
        end
        drain();

        // caret chain deeper than the stack: drops pushes, overflow stays set
        put_char(8'h61, 1'b0);
        repeat (STACK_DEPTH + 2)
        begin
            put_char(CHAR_CARET, 1'b0);
            put_char(pick_operand(), 1'b0);
        end
        put_char(CHAR_PLUS, 1'b1);
        repeat (4) send_random_expr();
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_infix_to_postfix_converter_unit: clean");
        else
            $display("tb_infix_to_postfix_converter_unit: errors");
        $finish;
    end

endmodule
